@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/srss_pkg.sv @@
// Package with operation codes and field widths of the symbol rank/select store.
`timescale 1ns / 1ps

package srss_pkg;

  localparam int KIND_W  = 3;
  localparam int SYM_W   = 7;
  localparam int POS_W   = 11;
  localparam int VALUE_W = 12;

  // Operation codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIRST  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LAST   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SELECT = 3'd5;

  localparam logic [VALUE_W-1:0] VALUE_NONE = {VALUE_W{1'b1}};

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [VALUE_W-1:0] value_t;

endpackage

@@ rtl/symbol_rank_select_store.sv @@
// Symbol rank/select store: top level with symbol memory, scan sequencer and output register.
//
// Usage: one transaction on the in_ channel carries one operation (push, pop,
// count, first, last, select); each gives exactly one transaction on the out_
// channel with value, status and the stored length after the operation.
// Push, pop and any rejected operation pass from acceptance straight to the
// hand-over state. A query over [range_lo, range_hi) reads the symbol memory
// one position per cycle through its single read port, then passes through
// a tail and a finish state before hand-over; an empty range goes straight
// to the finish state. One operation is in work at a time; in_stall is
// high from acceptance until its result is handed to the output register.
// The output register holds its transaction while out_stall is high; the
// sequencer keeps a finished result pending meanwhile, so one more operation
// may be accepted and worked on before the receiver drains.
// Reset clears the stored length and all control state; memory contents are
// not cleared, since entries at or beyond the stored length are never read.
`timescale 1ns / 1ps

module symbol_rank_select_store #(
  parameter int MAX_LEN  = 1024,
  parameter int ALPHABET = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  srss_pkg::kind_t        in_kind,
  input  srss_pkg::sym_t         in_symbol,
  input  srss_pkg::pos_t         in_range_lo,
  input  srss_pkg::pos_t         in_range_hi,
  input  srss_pkg::pos_t         in_occurrence,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [11:0]     out_value,
  output logic                   out_status,
  output srss_pkg::pos_t         out_length
);

  import srss_pkg::*;

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int ALPH_W = 9;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_TAIL = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  kind_t            kind_r, kind_nxt;
  sym_t             sym_r, sym_nxt;
  pos_t             idx_r, idx_nxt;
  pos_t             hi_r, hi_nxt;
  pos_t             occ_r, occ_nxt;
  pos_t             hits_r, hits_nxt;
  pos_t             found_r, found_nxt;
  logic             found_vld_r, found_vld_nxt;
  pos_t             pos_r;
  logic             rd_vld_r, rd_vld_nxt;
  sym_t             rd_data_r;
  value_t           res_value_r, res_value_nxt;
  logic             res_status_r, res_status_nxt;
  logic             out_valid_r;
  value_t           out_value_r;
  logic             out_status_r;
  pos_t             out_length_r;

  sym_t             sym_mem [MAX_LEN];
  logic             accept;
  logic             mem_we;
  logic [ADDR_W-1:0] rd_addr;
  logic             sym_bad;
  logic             range_bad;
  logic             hit;
  logic             out_free;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign sym_bad  = (ALPH_W'(in_symbol) >= ALPH_W'(ALPHABET));
  assign range_bad = (in_range_lo > in_range_hi) ||
                     (CMP_W'(in_range_hi) > CMP_W'(len_r));
  assign mem_we   = accept && (in_kind == KIND_PUSH) && !sym_bad &&
                    (len_r < LEN_W'(MAX_LEN));
  assign rd_addr  = ADDR_W'(idx_r);
  assign hit      = rd_vld_r && (rd_data_r == sym_r);

  // Write pushed symbols at the current length
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sym_mem[ADDR_W'(len_r)] <= in_symbol;
    end
  end

  // Read one scan position per cycle
  always_ff @(posedge clk) begin
    rd_data_r <= sym_mem[rd_addr];
    pos_r     <= idx_r;
  end

  // Sequencer: decode, scan, finish, hand over
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    kind_nxt       = kind_r;
    sym_nxt        = sym_r;
    idx_nxt        = idx_r;
    hi_nxt         = hi_r;
    occ_nxt        = occ_r;
    hits_nxt       = hits_r;
    found_nxt      = found_r;
    found_vld_nxt  = found_vld_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    rd_vld_nxt     = (state_r == ST_SCAN);

    // Count hits on returning read data
    if (hit) begin
      hits_nxt = hits_r + 1'b1;
      case (kind_r)
        KIND_FIRST: begin
          if (!found_vld_r) begin
            found_nxt     = pos_r;
            found_vld_nxt = 1'b1;
          end
        end
        KIND_LAST: begin
          found_nxt     = pos_r;
          found_vld_nxt = 1'b1;
        end
        KIND_SELECT: begin
          if (hits_r + 1'b1 == occ_r) begin
            found_nxt     = pos_r;
            found_vld_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt       = in_kind;
          sym_nxt        = in_symbol;
          idx_nxt        = in_range_lo;
          hi_nxt         = in_range_hi;
          occ_nxt        = in_occurrence;
          hits_nxt       = '0;
          found_vld_nxt  = 1'b0;
          res_value_nxt  = '0;
          res_status_nxt = 1'b1;
          state_nxt      = ST_DONE;
          case (in_kind) inside
            KIND_POP: begin
              if (len_r != '0) begin
                len_nxt        = len_r - 1'b1;
                res_status_nxt = 1'b0;
              end
            end
            KIND_PUSH: begin
              if (mem_we) begin
                len_nxt        = len_r + 1'b1;
                res_status_nxt = 1'b0;
              end
            end
            KIND_COUNT, KIND_FIRST, KIND_LAST, KIND_SELECT: begin
              if (!sym_bad && !range_bad) begin
                state_nxt = (in_range_lo == in_range_hi) ? ST_FIN : ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == hi_r - 1'b1) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        res_status_nxt = 1'b0;
        case (kind_r)
          KIND_COUNT: begin
            res_value_nxt = VALUE_W'(hits_r);
          end
          KIND_SELECT: begin
            if (occ_r == '0 || occ_r > hits_r) begin
              res_value_nxt  = '0;
              res_status_nxt = 1'b1;
            end else begin
              res_value_nxt = VALUE_W'(found_r);
            end
          end
          default: begin
            res_value_nxt = found_vld_r ? VALUE_W'(found_r) : VALUE_NONE;
          end
        endcase
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state and length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // Advance operation payload
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    sym_r        <= sym_nxt;
    idx_r        <= idx_nxt;
    hi_r         <= hi_nxt;
    occ_r        <= occ_nxt;
    hits_r       <= hits_nxt;
    found_r      <= found_nxt;
    found_vld_r  <= found_vld_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  // Output register: load a pending result when free, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_length_r <= POS_W'(len_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_length = out_length_r;

endmodule

@@ rtl/srss_checker.sv @@
// Port-level checker for the symbol rank/select store, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic signed [11:0]  out_value,
  input logic                out_status,
  input srss_pkg::pos_t      out_length
);

  import srss_pkg::*;

  // An accepted input transaction blocks the next one
  `ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall)

  // A stalled result transaction holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_status) && $stable(out_length))

  // An error result always carries a zero value
  `ASSERT_NOW(a_err_zero, out_valid && out_status, out_value == '0)

  // The only negative value is the no-occurrence marker
  `ASSERT_NOW(a_neg_none, out_valid && out_value[11], out_value == VALUE_NONE && !out_status)

endmodule

bind symbol_rank_select_store srss_checker u_srss_checker (.*);
